/* sv/tehs_pkg.sv */
// Shared types and codes for the timed event heap scheduler.
// Used by timed_event_heap_scheduler_core; no dependencies.
package tehs_pkg;

    typedef enum logic [1:0] {
        MODE_ADD        = 2'd0,
        MODE_CANCEL_H   = 2'd1,
        MODE_CANCEL_S   = 2'd2,
        MODE_TICK       = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_ADDED      = 3'd0,
        KIND_FIRED      = 3'd1,
        KIND_CANCELLED  = 3'd2,
        KIND_NO_MATCH   = 3'd3,
        KIND_TICK_DONE  = 3'd4,
        KIND_FULL       = 3'd5
    } kind_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] event_time;
        logic [31:0] repeat_interval_in;
        logic [15:0] repeat_count;
        logic [7:0]  owner_id;
        logic [15:0] tag_id;
        logic [5:0]  handle_in;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  handle_out;
        logic [7:0]  owner_out;
        logic [15:0] tag_out;
        logic        last_result;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_INS_RD,
        ST_INS_CMP,
        ST_CH_CHK,
        ST_SR_RD,
        ST_SR_SLOT,
        ST_SR_CHK,
        ST_TK_TOP,
        ST_TK_CHK,
        ST_TK_LAST,
        ST_SD_L,
        ST_SD_R,
        ST_SD_C,
        ST_TK_ACT,
        ST_FIN
    } st_t;

endpackage

/* sv/timed_event_heap_scheduler_core.sv */
// Timer event queue: binary min-heap of slot handles in a heap memory, slot
// records in a record memory, one sequencer walking both. Uses tehs_pkg.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (tehs_pkg::req_t)
//   result  | rsp_valid | rsp_stall | rsp (tehs_pkg::rsp_t)
//
// One request at a time; req_stall is high until its final result is loaded.
// Add: lowest-free scan (one slot per cycle), then sift up one heap level at a time.
// Cancel by handle: one record read and check. Cancel by search: walks heap entries in index order.
// Tick: pops each due entry, sifts down, and re-inserts repeating ones by sift up.
// Reset clears state, heap count, slot-in-use bits, fire count, insert flag and result valid; no clearing pass.
// A stalled result holds the sequencer only when a new result must be loaded.
module timed_event_heap_scheduler_core #(
    parameter int SLOTS     = 64,
    parameter int MAX_FIRE  = 63,
    parameter int TIME_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  tehs_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output tehs_pkg::rsp_t   rsp
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = IW + 1;
    localparam int HW = (IW > 6) ? IW + 1 : 7;
    localparam int TB = TIME_BITS;

    typedef struct packed {
        logic [IW-1:0] slot;
        logic [TB-1:0] due;
    } ent_t;

    typedef struct packed {
        logic [TB-1:0] interval;
        logic [15:0]   remaining;
        logic          repeating;
        logic          cancelled;
        logic [7:0]    owner;
        logic [15:0]   tag;
    } rec_t;

    // memories
    ent_t heap_mem [SLOTS];
    rec_t rec_mem  [SLOTS];

    logic          hw_en, hr_en, rw_en, rr_en;
    logic [IW-1:0] hw_addr, hr_addr, rw_addr, rr_addr;
    ent_t          hw_data;
    rec_t          rw_data;
    ent_t          hrd_reg;
    rec_t          rrd_reg;

    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            heap_mem[hw_addr] <= hw_data;
        end
        if (hr_en)
        begin
            hrd_reg <= heap_mem[hr_addr];
        end
        if (rw_en)
        begin
            rec_mem[rw_addr] <= rw_data;
        end
        if (rr_en)
        begin
            rrd_reg <= rec_mem[rr_addr];
        end
    end

    tehs_pkg::st_t    state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    pos_reg, pos_next;
    logic [IW-1:0]    slot_reg, slot_next;
    ent_t             ent_reg, ent_next;
    ent_t             lch_reg, lch_next;
    ent_t             top_reg, top_next;
    logic [5:0]       fires_reg, fires_next;
    logic             ins_tick_reg, ins_tick_next;
    tehs_pkg::req_t   req_reg, req_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [2:0]       res_kind_reg, res_kind_next;
    logic             res_show_reg, res_show_next;
    logic             out_valid_reg, out_valid_next;
    tehs_pkg::rsp_t   out_reg, out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tehs_pkg::ST_IDLE;
            count_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            fires_reg     <= '0;
            ins_tick_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            fires_reg     <= fires_next;
            ins_tick_reg  <= ins_tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        slot_reg     <= slot_next;
        ent_reg      <= ent_next;
        lch_reg      <= lch_next;
        top_reg      <= top_next;
        req_reg      <= req_next;
        res_kind_reg <= res_kind_next;
        res_show_reg <= res_show_next;
        out_reg      <= out_next;
    end

    assign req_stall = (state_reg != tehs_pkg::ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    logic          can_emit;
    logic [TB-1:0] req_time, req_ival, new_due;
    logic [TB:0]   due_sum;
    logic [HW-1:0] h_ext;
    logic          h_ok;
    logic [IW-1:0] h_idx;
    logic [IW+1:0] l_idx, r_idx;
    logic          r_ok, use_l, use_r;
    logic [TB-1:0] best_due;
    logic [15:0]   rem_dec;

    always_comb
    begin
        can_emit = !out_valid_reg || !rsp_stall;
        req_time = TB'(req_reg.event_time);
        req_ival = TB'(req_reg.repeat_interval_in);
        h_ext    = HW'(req.handle_in);
        h_ok     = h_ext < HW'(SLOTS);
        h_idx    = h_ext[IW-1:0];
        l_idx    = {1'b0, pos_reg, 1'b1};
        r_idx    = l_idx + (IW+2)'(1);
        r_ok     = r_idx < (IW+2)'(count_reg);
        use_l    = ent_reg.due > lch_reg.due;
        best_due = use_l ? lch_reg.due : ent_reg.due;
        use_r    = r_ok && (best_due > hrd_reg.due);
        due_sum  = {1'b0, top_reg.due} + {1'b0, rrd_reg.interval};
        new_due  = due_sum[TB] ? {TB{1'b1}} : due_sum[TB-1:0];
        rem_dec  = rrd_reg.remaining - 16'd1;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        slot_next      = slot_reg;
        ent_next       = ent_reg;
        lch_next       = lch_reg;
        top_next       = top_reg;
        fires_next     = fires_reg;
        ins_tick_next  = ins_tick_reg;
        req_next       = req_reg;
        used_next      = used_reg;
        res_kind_next  = res_kind_reg;
        res_show_next  = res_show_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        hw_en   = 1'b0;
        hw_addr = pos_reg;
        hw_data = ent_reg;
        hr_en   = 1'b0;
        hr_addr = '0;
        rw_en   = 1'b0;
        rw_addr = slot_reg;
        rw_data = rrd_reg;
        rr_en   = 1'b0;
        rr_addr = slot_reg;

        case (state_reg)
            tehs_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    idx_next   = '0;
                    fires_next = '0;
                    case (req.mode)
                        tehs_pkg::MODE_ADD:
                        begin
                            if (count_reg >= CW'(SLOTS))
                            begin
                                res_kind_next = tehs_pkg::KIND_FULL;
                                res_show_next = 1'b0;
                                state_next    = tehs_pkg::ST_FIN;
                            end
                            else
                            begin
                                state_next = tehs_pkg::ST_ADD_SCAN;
                            end
                        end
                        tehs_pkg::MODE_CANCEL_H:
                        begin
                            if (h_ok && used_reg[h_idx])
                            begin
                                slot_next  = h_idx;
                                rr_en      = 1'b1;
                                rr_addr    = h_idx;
                                state_next = tehs_pkg::ST_CH_CHK;
                            end
                            else
                            begin
                                res_kind_next = tehs_pkg::KIND_NO_MATCH;
                                res_show_next = 1'b0;
                                state_next    = tehs_pkg::ST_FIN;
                            end
                        end
                        tehs_pkg::MODE_CANCEL_S:
                        begin
                            state_next = tehs_pkg::ST_SR_RD;
                        end
                        default:
                        begin
                            state_next = tehs_pkg::ST_TK_TOP;
                        end
                    endcase
                end
            end

            tehs_pkg::ST_ADD_SCAN:
            begin
                if (!used_reg[idx_reg[IW-1:0]])
                begin
                    slot_next                  = idx_reg[IW-1:0];
                    used_next[idx_reg[IW-1:0]] = 1'b1;
                    rw_en             = 1'b1;
                    rw_addr           = idx_reg[IW-1:0];
                    rw_data.cancelled = 1'b0;
                    rw_data.owner     = req_reg.owner_id;
                    rw_data.tag       = req_reg.tag_id;
                    if (req_reg.repeat_count == 16'd1)
                    begin
                        rw_data.repeating = 1'b0;
                        rw_data.interval  = '0;
                        rw_data.remaining = 16'd1;
                    end
                    else
                    begin
                        rw_data.repeating = 1'b1;
                        rw_data.interval  = req_ival;
                        rw_data.remaining = (req_reg.repeat_count != 16'd0) ?
                                            req_reg.repeat_count - 16'd1 : 16'd0;
                    end
                    ent_next.slot = idx_reg[IW-1:0];
                    ent_next.due  = req_time;
                    pos_next      = count_reg[IW-1:0];
                    count_next    = count_reg + CW'(1);
                    ins_tick_next = 1'b0;
                    state_next    = tehs_pkg::ST_INS_RD;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            // sift up: hole at pos, moving entry in ent_reg
            tehs_pkg::ST_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    hw_en = 1'b1;
                    if (ins_tick_reg)
                    begin
                        state_next = tehs_pkg::ST_TK_TOP;
                    end
                    else
                    begin
                        res_kind_next = tehs_pkg::KIND_ADDED;
                        res_show_next = 1'b1;
                        state_next    = tehs_pkg::ST_FIN;
                    end
                end
                else
                begin
                    hr_en      = 1'b1;
                    hr_addr    = (pos_reg - IW'(1)) >> 1;
                    state_next = tehs_pkg::ST_INS_CMP;
                end
            end

            tehs_pkg::ST_INS_CMP:
            begin
                hw_en = 1'b1;
                if (ent_reg.due >= hrd_reg.due)
                begin
                    if (ins_tick_reg)
                    begin
                        state_next = tehs_pkg::ST_TK_TOP;
                    end
                    else
                    begin
                        res_kind_next = tehs_pkg::KIND_ADDED;
                        res_show_next = 1'b1;
                        state_next    = tehs_pkg::ST_FIN;
                    end
                end
                else
                begin
                    hw_data    = hrd_reg;
                    pos_next   = (pos_reg - IW'(1)) >> 1;
                    state_next = tehs_pkg::ST_INS_RD;
                end
            end

            tehs_pkg::ST_CH_CHK:
            begin
                res_show_next = 1'b0;
                res_kind_next = tehs_pkg::KIND_NO_MATCH;
                if (!rrd_reg.cancelled && rrd_reg.owner == req_reg.owner_id &&
                    rrd_reg.tag == req_reg.tag_id)
                begin
                    rw_en             = 1'b1;
                    rw_data.cancelled = 1'b1;
                    res_kind_next     = tehs_pkg::KIND_CANCELLED;
                    res_show_next     = 1'b1;
                end
                state_next = tehs_pkg::ST_FIN;
            end

            tehs_pkg::ST_SR_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    res_kind_next = tehs_pkg::KIND_NO_MATCH;
                    res_show_next = 1'b0;
                    state_next    = tehs_pkg::ST_FIN;
                end
                else
                begin
                    hr_en      = 1'b1;
                    hr_addr    = idx_reg[IW-1:0];
                    state_next = tehs_pkg::ST_SR_SLOT;
                end
            end

            tehs_pkg::ST_SR_SLOT:
            begin
                slot_next  = hrd_reg.slot;
                rr_en      = 1'b1;
                rr_addr    = hrd_reg.slot;
                state_next = tehs_pkg::ST_SR_CHK;
            end

            tehs_pkg::ST_SR_CHK:
            begin
                if (!rrd_reg.cancelled && rrd_reg.owner == req_reg.owner_id &&
                    rrd_reg.tag == req_reg.tag_id)
                begin
                    rw_en             = 1'b1;
                    rw_data.cancelled = 1'b1;
                    res_kind_next     = tehs_pkg::KIND_CANCELLED;
                    res_show_next     = 1'b1;
                    state_next        = tehs_pkg::ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = tehs_pkg::ST_SR_RD;
                end
            end

            tehs_pkg::ST_TK_TOP:
            begin
                if (count_reg == '0 || fires_reg == 6'(MAX_FIRE))
                begin
                    res_kind_next = tehs_pkg::KIND_TICK_DONE;
                    res_show_next = 1'b0;
                    state_next    = tehs_pkg::ST_FIN;
                end
                else
                begin
                    hr_en      = 1'b1;
                    hr_addr    = '0;
                    state_next = tehs_pkg::ST_TK_CHK;
                end
            end

            tehs_pkg::ST_TK_CHK:
            begin
                if (hrd_reg.due > req_time)
                begin
                    res_kind_next = tehs_pkg::KIND_TICK_DONE;
                    res_show_next = 1'b0;
                    state_next    = tehs_pkg::ST_FIN;
                end
                else
                begin
                    top_next   = hrd_reg;
                    slot_next  = hrd_reg.slot;
                    count_next = count_reg - CW'(1);
                    hr_en      = 1'b1;
                    hr_addr    = IW'(count_reg - CW'(1));
                    rr_en      = 1'b1;
                    rr_addr    = hrd_reg.slot;
                    state_next = tehs_pkg::ST_TK_LAST;
                end
            end

            tehs_pkg::ST_TK_LAST:
            begin
                ent_next   = hrd_reg;
                pos_next   = '0;
                state_next = (count_reg == '0) ? tehs_pkg::ST_TK_ACT : tehs_pkg::ST_SD_L;
            end

            // sift down: hole at pos, moving entry in ent_reg
            tehs_pkg::ST_SD_L:
            begin
                if (l_idx >= (IW+2)'(count_reg))
                begin
                    hw_en      = 1'b1;
                    state_next = tehs_pkg::ST_TK_ACT;
                end
                else
                begin
                    hr_en      = 1'b1;
                    hr_addr    = l_idx[IW-1:0];
                    state_next = tehs_pkg::ST_SD_R;
                end
            end

            tehs_pkg::ST_SD_R:
            begin
                lch_next = hrd_reg;
                if (r_ok)
                begin
                    hr_en   = 1'b1;
                    hr_addr = r_idx[IW-1:0];
                end
                state_next = tehs_pkg::ST_SD_C;
            end

            tehs_pkg::ST_SD_C:
            begin
                hw_en = 1'b1;
                if (use_r)
                begin
                    hw_data    = hrd_reg;
                    pos_next   = r_idx[IW-1:0];
                    state_next = tehs_pkg::ST_SD_L;
                end
                else if (use_l)
                begin
                    hw_data    = lch_reg;
                    pos_next   = l_idx[IW-1:0];
                    state_next = tehs_pkg::ST_SD_L;
                end
                else
                begin
                    state_next = tehs_pkg::ST_TK_ACT;
                end
            end

            tehs_pkg::ST_TK_ACT:
            begin
                if (rrd_reg.cancelled)
                begin
                    used_next[slot_reg] = 1'b0;
                    state_next          = tehs_pkg::ST_TK_TOP;
                end
                else if (can_emit)
                begin
                    out_valid_next      = 1'b1;
                    out_next.kind       = tehs_pkg::KIND_FIRED;
                    out_next.handle_out = 6'(slot_reg);
                    out_next.owner_out  = rrd_reg.owner;
                    out_next.tag_out    = rrd_reg.tag;
                    out_next.last_result = 1'b0;
                    fires_next          = fires_reg + 6'd1;
                    if (!rrd_reg.repeating)
                    begin
                        used_next[slot_reg] = 1'b0;
                        state_next          = tehs_pkg::ST_TK_TOP;
                    end
                    else
                    begin
                        rw_en = 1'b1;
                        if (rrd_reg.remaining != 16'd0)
                        begin
                            rw_data.remaining = rem_dec;
                            rw_data.repeating = (rem_dec != 16'd0);
                        end
                        ent_next.slot = slot_reg;
                        ent_next.due  = new_due;
                        pos_next      = count_reg[IW-1:0];
                        count_next    = count_reg + CW'(1);
                        ins_tick_next = 1'b1;
                        state_next    = tehs_pkg::ST_INS_RD;
                    end
                end
            end

            tehs_pkg::ST_FIN:
            begin
                if (can_emit)
                begin
                    out_valid_next       = 1'b1;
                    out_next.kind        = res_kind_reg;
                    out_next.handle_out  = res_show_reg ? 6'(slot_reg) : 6'd0;
                    out_next.owner_out   = res_show_reg ? req_reg.owner_id : 8'd0;
                    out_next.tag_out     = res_show_reg ? req_reg.tag_id : 16'd0;
                    out_next.last_result = 1'b1;
                    state_next           = tehs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tehs_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("heap count beyond slot count");

    a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
        fires_reg <= 6'(MAX_FIRE))
        else $error("fire count beyond limit");

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind == tehs_pkg::KIND_FIRED |-> !rsp.last_result)
        else $error("fired result marked last");

    a_idle_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) && rsp.last_result |-> state_reg == tehs_pkg::ST_IDLE)
        else $error("final result loaded while busy");
`endif

endmodule
